@@ design/arat_pkg.sv @@
// shared types and constants of the address range table
package arat_pkg;

  // table depth and field widths
  localparam int ENTRIES   = 16;
  localparam int ADDR_W    = 64;
  localparam int CFG_IDX_W = 1;

  // operation codes carried on in_func
  typedef enum logic [2:0] {
    FUNC_INSERT = 3'd0,
    FUNC_REMOVE = 3'd1,
    FUNC_CLEAR  = 3'd2,
    FUNC_RANGE  = 3'd3,
    FUNC_WINDOW = 3'd4
  } func_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd1;

  // registered request beat handed to the table
  typedef struct packed {
    logic              vld;
    func_t             func;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
  } op_t;

  // table status back to the result stage
  typedef struct packed {
    logic range_hit;
    logic full;
  } tbl_status_t;

endpackage

@@ design/address_range_table_unit.sv @@
// address range table top level: request register, range table, window check and result register
//
// Usage:
//   A command beat (in_func, in_address, in_length) is taken at a rising edge
//   where start is high and busy is low. busy is high during reset and drops at
//   the first edge that sees rst_n high, so a new beat may be issued every cycle.
//   The command is registered, then evaluated against the range table and the
//   window registers; its result (out_hit, out_status) is registered and shown
//   with out_valid for exactly one cycle, in which the receiver takes it.
//   Throughput is one beat per cycle once busy is low; a result passes through
//   the request register and the result register. Table updates from one beat
//   are seen by the next beat.
//   Window base and size are written through cfg_we, cfg_index and cfg_wdata
//   at any edge; they should only change while no command is in flight.
//   The receiver cannot stall: each result is taken in the cycle it shows.
//   A synchronous reset (rst_n low) empties the table, zeroes the window
//   registers and drops any command in flight.
module address_range_table_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     in_func,
  input  logic [arat_pkg::ADDR_W-1:0]    in_address,
  input  logic [arat_pkg::ADDR_W-1:0]    in_length,
  output logic                           out_valid,
  output logic                           out_hit,
  output logic                           out_status,
  input  logic                           cfg_we,
  input  logic [arat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arat_pkg::ADDR_W-1:0]    cfg_wdata
);

  logic                        busy_r;
  arat_pkg::op_t               req_r;
  arat_pkg::op_t               req_nxt;
  arat_pkg::tbl_status_t       tbl_sts;
  logic [arat_pkg::ADDR_W-1:0] window_base_r;
  logic [arat_pkg::ADDR_W-1:0] window_size_r;
  logic [arat_pkg::ADDR_W-1:0] window_end;
  logic                        win_hit;
  logic                        hit_nxt;
  logic                        status_nxt;
  logic                        out_valid_r;
  logic                        out_hit_r;
  logic                        out_status_r;

  // busy only while in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // request register
  always_comb begin
    req_nxt.vld     = start && !busy_r;
    req_nxt.func    = arat_pkg::func_t'(in_func);
    req_nxt.address = in_address;
    req_nxt.length  = in_length;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.vld <= 1'b0;
    end else begin
      req_r.vld <= req_nxt.vld;
    end
    req_r.func    <= req_nxt.func;
    req_r.address <= req_nxt.address;
    req_r.length  <= req_nxt.length;
  end

  // window configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_base_r <= '0;
      window_size_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        arat_pkg::REG_WINDOW_BASE: window_base_r <= cfg_wdata;
        arat_pkg::REG_WINDOW_SIZE: window_size_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // range table
  arat_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (req_r),
    .sts   (tbl_sts)
  );

  // window check, end inclusive; address zero never hits, and a window whose end wraps past the top matches nothing
  assign window_end = window_base_r + window_size_r;
  assign win_hit    = (req_r.address != '0) && (req_r.address >= window_base_r) &&
                      (req_r.address <= window_end);

  // result select by operation
  always_comb begin
    hit_nxt    = 1'b0;
    status_nxt = 1'b0;
    case (req_r.func)
      arat_pkg::FUNC_INSERT: status_nxt = tbl_sts.full;
      arat_pkg::FUNC_RANGE:  hit_nxt    = tbl_sts.range_hit;
      arat_pkg::FUNC_WINDOW: hit_nxt    = win_hit;
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_hit_r    <= 1'b0;
      out_status_r <= 1'b0;
    end else begin
      out_valid_r  <= req_r.vld;
      out_hit_r    <= req_r.vld && hit_nxt;
      out_status_r <= req_r.vld && status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = out_hit_r;
  assign out_status = out_status_r;

endmodule

@@ design/arat_table.sv @@
// range entry storage with insert, remove, clear and parallel range match
module arat_table (
  input  logic                  clk,
  input  logic                  rst_n,
  input  arat_pkg::op_t         op,
  output arat_pkg::tbl_status_t sts
);

  logic [arat_pkg::ENTRIES-1:0] valid_r;
  logic [arat_pkg::ENTRIES-1:0] valid_nxt;
  logic [arat_pkg::ADDR_W-1:0]  base_r   [arat_pkg::ENTRIES];
  logic [arat_pkg::ADDR_W-1:0]  end_r    [arat_pkg::ENTRIES];
  logic [arat_pkg::ADDR_W-1:0]  base_nxt [arat_pkg::ENTRIES];
  logic [arat_pkg::ADDR_W-1:0]  end_nxt  [arat_pkg::ENTRIES];
  logic [arat_pkg::ADDR_W-1:0]  base_up  [arat_pkg::ENTRIES];
  logic [arat_pkg::ADDR_W-1:0]  end_up   [arat_pkg::ENTRIES];
  logic [arat_pkg::ENTRIES-1:0] valid_up;
  logic [arat_pkg::ENTRIES:0]   occ_below;
  logic [arat_pkg::ENTRIES-1:0] in_range;
  logic [arat_pkg::ENTRIES-1:0] rm_match;
  logic [arat_pkg::ENTRIES-1:0] rm_shift;
  logic [arat_pkg::ENTRIES-1:0] ins_sel;
  logic [arat_pkg::ADDR_W-1:0]  ins_end;
  logic                         addr_zero;
  logic                         full;

  // per-entry compares against the probed address
  always_comb begin
    addr_zero = (op.address == '0);
    for (int i = 0; i < arat_pkg::ENTRIES; i++) begin
      in_range[i] = valid_r[i] && (op.address >= base_r[i]) && (op.address <= end_r[i]);
      rm_match[i] = valid_r[i] && (base_r[i] == op.address);
    end
  end

  // entries at or after the earliest match close up by one slot
  always_comb begin
    rm_shift[0] = rm_match[0];
    for (int i = 1; i < arat_pkg::ENTRIES; i++) begin
      rm_shift[i] = rm_shift[i-1] | rm_match[i];
    end
  end

  // neighbor view for the close-up; the last slot empties
  always_comb begin
    for (int i = 0; i < arat_pkg::ENTRIES - 1; i++) begin
      valid_up[i] = valid_r[i+1];
      base_up[i]  = base_r[i+1];
      end_up[i]   = end_r[i+1];
    end
    valid_up[arat_pkg::ENTRIES-1] = 1'b0;
    base_up[arat_pkg::ENTRIES-1]  = base_r[arat_pkg::ENTRIES-1];
    end_up[arat_pkg::ENTRIES-1]   = end_r[arat_pkg::ENTRIES-1];
  end

  // first free slot: empty and either slot zero or with an occupied slot below it
  always_comb begin
    occ_below = {valid_r, 1'b1};
    for (int i = 0; i < arat_pkg::ENTRIES; i++) begin
      ins_sel[i] = !valid_r[i] && occ_below[i];
    end
  end

  assign full    = valid_r[arat_pkg::ENTRIES-1];
  assign ins_end = op.address + op.length;

  // next table contents for the current beat
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < arat_pkg::ENTRIES; i++) begin
      base_nxt[i] = base_r[i];
      end_nxt[i]  = end_r[i];
    end
    if (op.vld) begin
      case (op.func)
        arat_pkg::FUNC_INSERT: begin
          if (!full) begin
            for (int i = 0; i < arat_pkg::ENTRIES; i++) begin
              if (ins_sel[i]) begin
                valid_nxt[i] = 1'b1;
                base_nxt[i]  = op.address;
                end_nxt[i]   = ins_end;
              end
            end
          end
        end
        arat_pkg::FUNC_REMOVE: begin
          if (!addr_zero) begin
            for (int i = 0; i < arat_pkg::ENTRIES; i++) begin
              if (rm_shift[i]) begin
                valid_nxt[i] = valid_up[i];
                base_nxt[i]  = base_up[i];
                end_nxt[i]   = end_up[i];
              end
            end
          end
        end
        arat_pkg::FUNC_CLEAR: begin
          valid_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // valid bits reset, entry payload does not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < arat_pkg::ENTRIES; i++) begin
      base_r[i] <= base_nxt[i];
      end_r[i]  <= end_nxt[i];
    end
  end

  // status toward the result stage
  assign sts.range_hit = !addr_zero && (|in_range);
  assign sts.full      = full;

endmodule

@@ design/arat_checker.sv @@
// port-level checks of the address range table, bound to the top level
module arat_port_checks (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [2:0]                     in_func,
  input logic [arat_pkg::ADDR_W-1:0]    in_address,
  input logic                           out_valid,
  input logic                           out_hit,
  input logic                           out_status
);

  logic take;

  assign take = start && !busy;

  // every accepted beat yields a result once it has passed the request and result registers
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> ##1 out_valid)
    else $error("accepted beat produced no result");

  // no result fields without a result beat
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> (!out_hit && !out_status))
    else $error("result fields set without out_valid");

  // a beat never both hits and reports a dropped insert
  a_hit_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_status))
    else $error("hit and status both set");

  // a range query right after a clear must miss
  a_clear_then_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (in_func == arat_pkg::FUNC_CLEAR)) ##1
    (take && (in_func == arat_pkg::FUNC_RANGE)) |=> ##1 !out_hit)
    else $error("range query hit after clear");

  // window query at address zero misses
  a_window_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (in_func == arat_pkg::FUNC_WINDOW) && (in_address == '0)) |=> ##1 !out_hit)
    else $error("window query at address zero hit");

endmodule

bind address_range_table_unit arat_port_checks u_arat_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_func    (in_func),
  .in_address (in_address),
  .out_valid  (out_valid),
  .out_hit    (out_hit),
  .out_status (out_status)
);
